// ----- rtl/line_to_line_closest_distance_top_macros.svh -----
// Assertion macros used by the port-level checker of the closest-distance block.
`ifndef LINE_TO_LINE_CLOSEST_DISTANCE_TOP_MACROS_SVH
`define LINE_TO_LINE_CLOSEST_DISTANCE_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define L2LCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define L2LCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/l2lcd_pkg.sv -----
// Types and widths for the closest-distance pipeline.
package l2lcd_pkg;

  localparam int IN_W       = 24;
  localparam int NUM_IN     = 12;
  localparam int IN_TDATA_W = IN_W * NUM_IN;
  localparam int DIST_W     = 32;

  localparam int PROD_W  = 48;   // one term of the cross product
  localparam int C_W     = 49;   // cross product component, signed
  localparam int CMAG_W  = 48;
  localparam int D_W     = 25;   // position difference, signed
  localparam int DMAG_W  = 24;
  localparam int LIMB_W  = 24;
  localparam int DC_W    = 72;   // |d| * |c| per component
  localparam int TERM_W  = 73;
  localparam int DOT_W   = 75;
  localparam int NK_W    = 96;
  localparam int NORM_W  = 98;
  localparam int SQL_W   = 25;   // limb of |dot| for squaring
  localparam int PP_W    = 50;
  localparam int SQ_W    = 150;
  localparam int TOP_W   = 102;
  localparam int QUO_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int REM_W   = 35;

  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;

  typedef logic signed [IN_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]      dist_t;

endpackage

// ----- rtl/line_to_line_closest_distance_top.sv -----
// Distance of closest approach between two straight tracks, fully pipelined.
//
// Input channel s_*: one request per accepted beat carries both tracks in
// s_tdata, twelve signed 24-bit fields packed from the lowest bit up.
// Output channel m_*: m_tdata is the distance in unsigned 24.8 fixed point,
// floor(256*|d.c|/|c|), saturating at all ones; m_tuser is set for parallel
// or zero directions, and the distance is then zero.
// Throughput: one request per cycle while s_tready is high. Results pass
// through 11 arithmetic stages, 64 restoring division steps and 32
// square-root steps, one register each, and then the output register.
// Stalls: an output register backed by one skid entry holds results while
// m_tready is low; the pipeline freezes only once the skid entry is full,
// and s_tready drops in the same cycle. Nothing is lost or repeated.
// Reset: rst clears all valid bits and the output buffer; the block takes
// requests from the first cycle after reset.
module line_to_line_closest_distance_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // mom1_x, mom1_y, mom1_z, pos1_x, pos1_y, pos1_z,
  // mom2_x, mom2_y, mom2_z, pos2_x, pos2_y, pos2_z
  input  logic [l2lcd_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // closest_distance
  output l2lcd_pkg::dist_t                m_tdata,
  // parallel_flag
  output logic [0:0]                      m_tuser
);
  import l2lcd_pkg::*;

  coord_t fin [NUM_IN];
  logic   en;
  logic   sv;

  assign en       = !sv;
  assign s_tready = en;

  always_comb begin
    for (int i = 0; i < NUM_IN; i++) begin
      fin[i] = coord_t'(s_tdata[i*IN_W +: IN_W]);
    end
  end

  // mom1 = fin[0..2], pos1 = fin[3..5], mom2 = fin[6..8], pos2 = fin[9..11]
  logic signed [PROD_W-1:0] pa [3];
  logic signed [PROD_W-1:0] pb [3];
  logic signed [D_W-1:0]    dd1 [3];
  logic                     v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= fin[1] * fin[8];
      pb[0] <= fin[2] * fin[7];
      pa[1] <= fin[2] * fin[6];
      pb[1] <= fin[0] * fin[8];
      pa[2] <= fin[0] * fin[7];
      pb[2] <= fin[1] * fin[6];
      for (int k = 0; k < 3; k++) begin
        dd1[k] <= $signed({fin[3+k][IN_W-1], fin[3+k]})
                - $signed({fin[9+k][IN_W-1], fin[9+k]});
      end
    end
  end

  // Stage 2: cross product
  logic signed [C_W-1:0] cc [3];
  logic signed [D_W-1:0] dd2 [3];
  logic                  v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cc[k]  <= $signed({pa[k][PROD_W-1], pa[k]}) - $signed({pb[k][PROD_W-1], pb[k]});
        dd2[k] <= dd1[k];
      end
    end
  end

  // Stage 3: magnitudes and signs
  logic [CMAG_W-1:0] cm [3];
  logic [DMAG_W-1:0] dm [3];
  logic              cs [3];
  logic              ds [3];
  logic              v3;
  logic [C_W-1:0]    cneg [3];
  logic [D_W-1:0]    dneg [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cneg[k] = C_W'(-cc[k]);
      dneg[k] = D_W'(-dd2[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cs[k] <= cc[k][C_W-1];
        ds[k] <= dd2[k][D_W-1];
        cm[k] <= cc[k][C_W-1] ? cneg[k][CMAG_W-1:0] : cc[k][CMAG_W-1:0];
        dm[k] <= dd2[k][D_W-1] ? dneg[k][DMAG_W-1:0] : dd2[k][DMAG_W-1:0];
      end
    end
  end

  // Stage 4: partial products for d.c and |c|^2
  logic [2*LIMB_W-1:0] dcl [3];
  logic [2*LIMB_W-1:0] dch [3];
  logic [2*LIMB_W-1:0] sll [3];
  logic [2*LIMB_W-1:0] slh [3];
  logic [2*LIMB_W-1:0] shh [3];
  logic                neg4 [3];
  logic                par4;
  logic                v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dcl[k]  <= dm[k] * cm[k][LIMB_W-1:0];
        dch[k]  <= dm[k] * cm[k][CMAG_W-1:LIMB_W];
        sll[k]  <= cm[k][LIMB_W-1:0] * cm[k][LIMB_W-1:0];
        slh[k]  <= cm[k][CMAG_W-1:LIMB_W] * cm[k][LIMB_W-1:0];
        shh[k]  <= cm[k][CMAG_W-1:LIMB_W] * cm[k][CMAG_W-1:LIMB_W];
        neg4[k] <= cs[k] ^ ds[k];
      end
      par4 <= (cm[0] == '0) && (cm[1] == '0) && (cm[2] == '0);
    end
  end

  // Stage 5: assemble per-component terms
  logic signed [TERM_W-1:0] term [3];
  logic [NK_W-1:0]          nk [3];
  logic                     par5;
  logic                     v5;
  logic [DC_W-1:0]          dcmag [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dcmag[k] = {24'b0, dcl[k]} + {dch[k], 24'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        term[k] <= neg4[k] ? -$signed({1'b0, dcmag[k]}) : $signed({1'b0, dcmag[k]});
        nk[k]   <= {48'b0, sll[k]} + {23'b0, slh[k], 25'b0} + {shh[k], 48'b0};
      end
      par5 <= par4;
    end
  end

  // Stage 6: dot product and squared norm
  logic signed [DOT_W-1:0] dot;
  logic [NORM_W-1:0]       norm6;
  logic                    par6;
  logic                    v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot   <= DOT_W'(term[0]) + DOT_W'(term[1]) + DOT_W'(term[2]);
      norm6 <= {2'b0, nk[0]} + {2'b0, nk[1]} + {2'b0, nk[2]};
      par6  <= par5;
    end
  end

  // Stage 7: |dot|
  logic [DOT_W-1:0]  dmag;
  logic [NORM_W-1:0] norm7;
  logic              par7;
  logic              v7;
  logic [DOT_W-1:0]  dotneg;

  assign dotneg = DOT_W'(-dot);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag  <= dot[DOT_W-1] ? dotneg : dot;
      norm7 <= norm6;
      par7  <= par6;
    end
  end

  // Stage 8: partial products of |dot|^2 over 25-bit limbs
  logic [PP_W-1:0]   p00, p01, p02, p11, p12, p22;
  logic [NORM_W-1:0] norm8;
  logic              par8;
  logic              v8;
  logic [SQL_W-1:0]  a0, a1, a2;

  assign a0 = dmag[SQL_W-1:0];
  assign a1 = dmag[2*SQL_W-1:SQL_W];
  assign a2 = dmag[3*SQL_W-1:2*SQL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00   <= a0 * a0;
      p01   <= a0 * a1;
      p02   <= a0 * a2;
      p11   <= a1 * a1;
      p12   <= a1 * a2;
      p22   <= a2 * a2;
      norm8 <= norm7;
      par8  <= par7;
    end
  end

  // Stage 9: first reduction
  logic [76:0]       lo9;
  logic [51:0]       mid9;
  logic [75:0]       hi9;
  logic [NORM_W-1:0] norm9;
  logic              par9;
  logic              v9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo9   <= {27'b0, p00} + {1'b0, p01, 26'b0};
      mid9  <= {1'b0, p02, 1'b0} + {2'b0, p11};
      hi9   <= {25'b0, p12, 1'b0} + {1'b0, p22, 25'b0};
      norm9 <= norm8;
      par9  <= par8;
    end
  end

  // Stage 10: full square
  logic [SQ_W-1:0]   sq10;
  logic [NORM_W-1:0] norm10;
  logic              par10;
  logic              v10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq10   <= {73'b0, lo9} + {48'b0, mid9, 50'b0} + {hi9[74:0], 75'b0};
      norm10 <= norm9;
      par10  <= par9;
    end
  end

  // Stage 11: saturation test, then seed the divider with the top of 2^16*dot^2
  logic [NORM_W-1:0] dv_r   [DIV_STEPS+1];
  logic [QUO_W-1:0]  dv_lo  [DIV_STEPS+1];
  logic [QUO_W-1:0]  dv_q   [DIV_STEPS+1];
  logic [NORM_W-1:0] dv_n   [DIV_STEPS+1];
  logic              dv_sat [DIV_STEPS+1];
  logic              dv_par [DIV_STEPS+1];
  logic              dv_v   [DIV_STEPS+1];
  logic [TOP_W-1:0]  top10;

  assign top10 = sq10[SQ_W-1:SQ_W-TOP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]   <= top10[NORM_W-1:0];
      dv_lo[0]  <= {sq10[SQ_W-TOP_W-1:0], 16'b0};
      dv_q[0]   <= '0;
      dv_n[0]   <= norm10;
      dv_sat[0] <= top10 >= {4'b0, norm10};
      dv_par[0] <= par10;
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [NORM_W:0]   t;
    logic [NORM_W:0]   diff;
    logic              ge;

    assign t    = {dv_r[k], dv_lo[k][QUO_W-1]};
    assign diff = t - {1'b0, dv_n[k]};
    assign ge   = t >= {1'b0, dv_n[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1]   <= ge ? diff[NORM_W-1:0] : t[NORM_W-1:0];
        dv_lo[k+1]  <= {dv_lo[k][QUO_W-2:0], 1'b0};
        dv_q[k+1]   <= {dv_q[k][QUO_W-2:0], ge};
        dv_n[k+1]   <= dv_n[k];
        dv_sat[k+1] <= dv_sat[k];
        dv_par[k+1] <= dv_par[k];
      end
    end
  end

  // Integer square root, one root bit per stage
  logic [REM_W-1:0]  sr_rem  [SQRT_STEPS];
  logic [ROOT_W-1:0] sr_root [SQRT_STEPS];
  logic [QUO_W-1:0]  sr_val  [SQRT_STEPS];
  logic              sr_sat  [SQRT_STEPS];
  logic              sr_par  [SQRT_STEPS];
  logic              sr_v    [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [REM_W-1:0]  in_rem;
    logic [ROOT_W-1:0] in_root;
    logic [QUO_W-1:0]  in_val;
    logic              in_sat;
    logic              in_par;
    logic              in_v;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign in_rem  = '0;
      assign in_root = '0;
      assign in_val  = dv_q[DIV_STEPS];
      assign in_sat  = dv_sat[DIV_STEPS];
      assign in_par  = dv_par[DIV_STEPS];
      assign in_v    = dv_v[DIV_STEPS];
    end else begin : g_next
      assign in_rem  = sr_rem[j-1];
      assign in_root = sr_root[j-1];
      assign in_val  = sr_val[j-1];
      assign in_sat  = sr_sat[j-1];
      assign in_par  = sr_par[j-1];
      assign in_v    = sr_v[j-1];
    end

    assign t     = {in_rem, in_val[QUO_W-1:QUO_W-2]};
    assign trial = {3'b0, in_root, 2'b01};
    assign diff  = t - trial;
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_v[j] <= 1'b0;
      end else if (en) begin
        sr_v[j] <= in_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem[j]  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        sr_root[j] <= {in_root[ROOT_W-2:0], ge};
        sr_val[j]  <= {in_val[QUO_W-3:0], 2'b00};
        sr_sat[j]  <= in_sat;
        sr_par[j]  <= in_par;
      end
    end
  end

  // Output register with one skid entry
  dist_t item_dist;
  logic  item_flag;
  logic  item_v;
  dist_t sd;
  logic  sflag;

  assign item_v    = sr_v[SQRT_STEPS-1];
  assign item_flag = sr_par[SQRT_STEPS-1];
  assign item_dist = sr_par[SQRT_STEPS-1] ? '0 :
                     sr_sat[SQRT_STEPS-1] ? '1 : sr_root[SQRT_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sv       <= 1'b0;
    end else if (sv) begin
      if (m_tready) begin
        sv <= 1'b0;
      end
    end else if (m_tvalid && !m_tready) begin
      if (item_v) begin
        sv <= 1'b1;
      end
    end else begin
      m_tvalid <= item_v;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (m_tready) begin
        m_tdata <= sd;
        m_tuser <= sflag;
      end
    end else if (m_tvalid && !m_tready) begin
      sd    <= item_dist;
      sflag <= item_flag;
    end else begin
      m_tdata <= item_dist;
      m_tuser <= item_flag;
    end
  end

endmodule

// ----- rtl/l2lcd_checker.sv -----
// Port-level checks for the closest-distance block, bound to its top level.
`include "line_to_line_closest_distance_top_macros.svh"

module l2lcd_checker (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input l2lcd_pkg::dist_t m_tdata,
  input logic [0:0]       m_tuser
);
  import l2lcd_pkg::*;

  dist_t zero_dist;

  assign zero_dist = '0;

  `L2LCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `L2LCD_ASSERT_SAME(a_par_zero, m_tvalid && m_tuser[0], m_tdata == zero_dist, "parallel tracks with nonzero distance")
  `L2LCD_ASSERT_SAME(a_ready_empty, !m_tvalid, s_tready, "input blocked with empty output")

endmodule

bind line_to_line_closest_distance_top l2lcd_checker u_l2lcd_checker (.*);

// ----- tb/sv/l2lcd_checker.sv -----
// Scoreboard for the closest-distance block: predicts each request and checks each result.
`timescale 1ns / 1ps
module l2lcd_scoreboard (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [l2lcd_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  l2lcd_pkg::dist_t                 m_tdata,
  input  logic [0:0]                       m_tuser,
  output int                               errors,
  output int                               pending
);
  import l2lcd_pkg::*;

  typedef struct packed {
    dist_t distance;
    logic  parallel;
  } approach_t;

  approach_t dist_q[$];

  function automatic logic signed [63:0] field(logic [IN_TDATA_W-1:0] d, int i);
    coord_t v;
    v = d[IN_W*i +: IN_W];
    return 64'(v);
  endfunction

  // Exact floor(256*|d.c|/|c|) by bitwise search on q*q*|c|^2 <= 65536*(d.c)^2
  function automatic approach_t closest_approach(logic [IN_TDATA_W-1:0] d);
    logic signed [63:0]  m1x, m1y, m1z, q1x, q1y, q1z, m2x, m2y, m2z, q2x, q2y, q2z;
    logic signed [255:0] cx, cy, cz, dx, dy, dz, dot;
    logic [255:0]        norm, rhs, trial;
    logic [31:0]         q, cand;
    approach_t           r;
    m1x = field(d, 0); m1y = field(d, 1); m1z = field(d, 2);
    q1x = field(d, 3); q1y = field(d, 4); q1z = field(d, 5);
    m2x = field(d, 6); m2y = field(d, 7); m2z = field(d, 8);
    q2x = field(d, 9); q2y = field(d, 10); q2z = field(d, 11);
    cx = m1y * m2z - m1z * m2y;
    cy = m1z * m2x - m1x * m2z;
    cz = m1x * m2y - m1y * m2x;
    dx = q1x - q2x;
    dy = q1y - q2y;
    dz = q1z - q2z;
    if (cx == 0 && cy == 0 && cz == 0) begin
      r.distance = '0;
      r.parallel = 1'b1;
      return r;
    end
    dot = dx * cx + dy * cy + dz * cz;
    if (dot < 0) dot = -dot;
    norm = cx * cx + cy * cy + cz * cz;
    rhs  = (dot * dot) << 16;
    q = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = q | (32'd1 << b);
      trial = 256'(cand) * 256'(cand) * norm;
      if (trial <= rhs) q = cand;
    end
    r.distance = q;
    r.parallel = 1'b0;
    return r;
  endfunction

  assign pending = dist_q.size();

  always @(posedge clk) begin
    approach_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) dist_q.push_back(closest_approach(s_tdata));
      if (m_tvalid && m_tready) begin
        if (dist_q.size() == 0) begin
          $display("%0t: unexpected result dist=%h parallel=%b", $time, m_tdata, m_tuser);
          errors <= errors + 1;
        end else begin
          want = dist_q.pop_front();
          if (want.distance !== m_tdata || want.parallel !== m_tuser[0]) begin
            $display("%0t: mismatch expected dist=%h parallel=%b, actual dist=%h parallel=%b",
                     $time, want.distance, want.parallel, m_tdata, m_tuser);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/tb_line_to_line_closest_distance_top.sv -----
// Stimulus, clocking and verdict for the closest-distance block.
`timescale 1ns / 1ps
module tb_line_to_line_closest_distance_top;
  import l2lcd_pkg::*;

  localparam int N_RANDOM = 1830;
  localparam int LIMIT    = 300000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  dist_t                 m_tdata;
  logic [0:0]            m_tuser;
  logic                  calm = 1'b0;
  int                    errors, pending, cycles = 0, stall_left = 0;

  always #6 clk = ~clk;

  line_to_line_closest_distance_top DUT (.*);

  l2lcd_scoreboard checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver back-pressure in bursts, none in the closing stretch
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack(coord_t f[12]);
    logic [IN_TDATA_W-1:0] d;
    for (int i = 0; i < 12; i++) d[IN_W*i +: IN_W] = f[i];
    return d;
  endfunction

  task automatic send(logic [IN_TDATA_W-1:0] d);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tdata <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_tracks(coord_t a0, a1, a2, b0, b1, b2, c0, c1, c2, e0, e1, e2);
    coord_t f[12];
    f = '{a0, a1, a2, b0, b1, b2, c0, c1, c2, e0, e1, e2};
    send(pack(f));
  endtask

  function automatic coord_t small_val();
    return coord_t'($signed($urandom_range(0, 64)) - 32);
  endfunction

  initial begin
    coord_t f[12];
    coord_t k;
    int     kind;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero directions, parallel directions, anti-parallel
    send_tracks(0, 0, 0, 5, 6, 7, 0, 0, 0, -5, 1, 2);
    send_tracks(1, 2, 3, 0, 0, 0, 2, 4, 6, 9, 9, 9);
    send_tracks(3, -1, 2, 7, 0, 0, -6, 2, -4, 1, 1, 1);
    send_tracks(0, 0, 0, 1, 1, 1, 3, 4, 5, 0, 0, 0);
    // perpendicular axes, simple offsets
    send_tracks(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 10);
    send_tracks(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    send_tracks(1, 0, 0, 3, 4, 0, 0, 0, 1, 0, 0, 0);
    // saturation: cross (1,1,1), positions at opposite corners
    send_tracks(1, -1, 0, 8388607, 8388607, 8388607, 0, 1, -1, -8388608, -8388608, -8388608);
    send_tracks(1, -1, 0, -8388608, -8388608, -8388608, 0, 1, -1, 8388607, 8388607, 8388607);
    // extreme fields
    for (int i = 0; i < 12; i++) f[i] = -24'sd8388608;
    send(pack(f));
    for (int i = 0; i < 12; i++) f[i] = 24'sd8388607;
    send(pack(f));
    send_tracks(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                8388607, -8388608, 8388607, -8388608, 8388607, -8388608);
    send_tracks(8388607, 0, 0, 8388607, 8388607, 8388607, 0, -8388608, 0,
                -8388608, -8388608, -8388608);
    send_tracks(8388607, 8388607, 1, 0, 0, 0, 8388607, 8388606, 1, 1, -1, 1);
    send_tracks(-8388608, -8388608, -8388608, 100, 200, 300, 1, 1, 1, -100, -200, -300);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 150) calm <= 1'b1;
      for (int i = 0; i < 12; i++) f[i] = coord_t'($urandom());
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // scaled copy of the first direction
        for (int i = 0; i < 3; i++) f[i] = small_val();
        k = small_val();
        for (int i = 0; i < 3; i++) f[6+i] = f[i] * k;
      end else if (kind == 1) begin
        for (int i = 0; i < 3; i++) f[i] = '0;
      end else if (kind <= 4) begin
        for (int i = 0; i < 3; i++) f[i] = small_val();
        for (int i = 0; i < 3; i++) f[6+i] = small_val();
        if (kind == 4) for (int i = 0; i < 3; i++) f[3+i] = small_val();
      end
      send(pack(f));
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- line_to_line_closest_distance_top.f -----
+incdir+rtl
rtl/l2lcd_pkg.sv
rtl/line_to_line_closest_distance_top.sv
rtl/l2lcd_checker.sv
tb/sv/l2lcd_checker.sv
tb/sv/tb_line_to_line_closest_distance_top.sv
